FILE: hw/rtl/h3uh_pkg.sv
// Shared types and constants for the H3 universal hash block.
// No dependencies; every other RTL file except h3uh_ram imports this package.
`default_nettype none

package h3uh_pkg;

	localparam int HASH_W    = 32;
	localparam int BYTE_W    = 8;
	localparam int ROW_IDX_W = 8;

	// hash words per key; row_index is sized for this count
	localparam int WORDS = 2;

	// request kinds carried in req_type
	localparam logic REQ_LOAD = 1'b0;
	localparam logic REQ_KEY  = 1'b1;

	typedef logic [HASH_W-1:0] word_t;

	typedef struct packed {
		logic                 req_type;
		logic [ROW_IDX_W-1:0] row_index;
		word_t                row_value;
		logic [BYTE_W-1:0]    key_byte;
		logic                 last_byte;
	} item_t;

	typedef struct packed {
		word_t hash_word;
		logic  word_index;
		logic  last_word;
	} result_t;

	// key byte handed to the accumulate stage in the cycle it is accepted
	typedef struct packed {
		logic              valid;
		logic [BYTE_W-1:0] key_byte;
		logic              last_byte;
	} key_req_t;

endpackage

`default_nettype wire

FILE: hw/rtl/h3_universal_hash_top.sv
// Top level of the H3 universal hash: request channel, position counter, wiring.
// Depends on h3uh_pkg, h3uh_row_store, h3uh_accum and h3uh_out_buf.
//
// Usage:
//   item/item_valid/item_ready carries requests. A request with req_type
//   REQ_LOAD writes one 32-bit matrix row; REQ_KEY feeds the next key byte.
//   Load every row a key will touch before sending key bytes.
//   result/result_valid/result_ready returns WORDS hash words per key, word 0
//   first, last_word set on the final one.
//   Throughput: one request per cycle while item_ready is high. Each key byte
//   reads its rows from the bank RAMs in the accept cycle; the registered row
//   data and byte are then folded into the accumulators. The output buffer
//   holds one key's words, so a key's words leave at one per cycle while
//   result_ready is high; a key ending while the previous key's words still
//   drain holds item_ready low until the buffer frees. Word 0 of a key passes
//   the accumulate stage register and the output buffer; the rest follow it back to back.
//   Reset clears the accumulators, the byte position and the output buffer.
//   The row RAMs are not cleared and must be loaded after reset.
//   A stalled receiver holds result stable; requests keep flowing until a
//   finished key has nowhere to go.
`default_nettype none

module h3_universal_hash_top
	import h3uh_pkg::*;
(
	input  wire     clk,
	input  wire     arst_n,
	input  wire     item_valid,
	output logic    item_ready,
	input  item_t   item,
	output logic    result_valid,
	input  wire     result_ready,
	output result_t result
);

	localparam int POS   = 4 * (WORDS + 1);
	localparam int POS_W = $clog2(POS);

	logic             accept;
	logic             load_en;
	logic             key_en;
	logic [POS_W-1:0] pos_q;
	key_req_t         key;
	word_t            rows [WORDS][BYTE_W];
	word_t            words [WORDS];
	logic             stall;
	logic             buf_load;
	logic             buf_free;

	assign item_ready = !stall;
	assign accept     = item_valid && item_ready;
	assign load_en    = accept && (item.req_type == REQ_LOAD);
	assign key_en     = accept && (item.req_type == REQ_KEY);

	assign key.valid     = key_en;
	assign key.key_byte  = item.key_byte;
	assign key.last_byte = item.last_byte;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q <= '0;
		end else if (key_en) begin
			if (item.last_byte || pos_q == POS_W'(POS - 1)) begin
				pos_q <= '0;
			end else begin
				pos_q <= pos_q + 1'b1;
			end
		end
	end

	h3uh_row_store u_row_store (
		.clk      (clk),
		.wr_en    (load_en),
		.row_index(item.row_index),
		.row_value(item.row_value),
		.rd_en    (key_en),
		.rd_pos   (pos_q),
		.rows     (rows)
	);

	h3uh_accum u_accum (
		.clk     (clk),
		.arst_n  (arst_n),
		.key     (key),
		.rows    (rows),
		.buf_free(buf_free),
		.stall   (stall),
		.load    (buf_load),
		.words   (words)
	);

	h3uh_out_buf u_out_buf (
		.clk         (clk),
		.arst_n      (arst_n),
		.load        (buf_load),
		.words       (words),
		.buf_free    (buf_free),
		.result_valid(result_valid),
		.result_ready(result_ready),
		.result      (result)
	);

`ifndef SYNTHESIS
	a_pos_restart: assert property (@(posedge clk) disable iff (!arst_n)
		(key_en && item.last_byte) |=> (pos_q == '0))
		else $error("byte position not cleared at key end");

	a_pos_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(key_en && !item.last_byte && pos_q == POS_W'(POS - 1)) |=> (pos_q == '0))
		else $error("byte position did not wrap");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/h3uh_ram.sv
// Generic single-write, single-read synchronous RAM with registered read data.
// No dependencies.
`default_nettype none

module h3uh_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 12
) (
	input  wire                                   clk,
	input  wire                                   we,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire  [WIDTH-1:0]                      wdata,
	input  wire                                   re,
	input  wire  [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                      rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/h3uh_row_store.sv
// Matrix row store: one RAM bank per (hash word, byte bit), indexed by position.
// Depends on h3uh_pkg and h3uh_ram.
`default_nettype none

module h3uh_row_store
	import h3uh_pkg::*;
(
	input  wire                   clk,
	input  wire                   wr_en,
	input  wire  [ROW_IDX_W-1:0]  row_index,
	input  word_t                 row_value,
	input  wire                   rd_en,
	input  wire  [$clog2(4 * (WORDS + 1))-1:0] rd_pos,
	output word_t                 rows [WORDS][BYTE_W]
);

	localparam int POS       = 4 * (WORDS + 1);
	localparam int POS_W     = $clog2(POS);
	localparam int ROW_DEPTH = WORDS * POS * BYTE_W;
	localparam int BIT_W     = $clog2(BYTE_W);

	logic                         in_range;
	logic [ROW_IDX_W-BIT_W-1:0]   row_grp;
	logic [BIT_W-1:0]             row_bit;

	assign in_range = 32'(row_index) < 32'(ROW_DEPTH);
	assign row_grp  = row_index[ROW_IDX_W-1:BIT_W];
	assign row_bit  = row_index[BIT_W-1:0];

	for (genvar j = 0; j < WORDS; j++) begin : g_word
		localparam int LO = j * POS;
		localparam int HI = (j + 1) * POS;

		logic             hit;
		logic [31:0]      offset;
		logic [POS_W-1:0] waddr;

		// row group = word * POS + position
		assign hit    = (32'(row_grp) >= 32'(LO)) && (32'(row_grp) < 32'(HI));
		assign offset = 32'(row_grp) - 32'(LO);
		assign waddr  = offset[POS_W-1:0];

		for (genvar b = 0; b < BYTE_W; b++) begin : g_bit
			logic we;

			assign we = wr_en && in_range && hit && (row_bit == BIT_W'(b));

			h3uh_ram #(
				.WIDTH(HASH_W),
				.DEPTH(POS)
			) u_bank (
				.clk  (clk),
				.we   (we),
				.waddr(waddr),
				.wdata(row_value),
				.re   (rd_en),
				.raddr(rd_pos),
				.rdata(rows[j][b])
			);
		end
	end

endmodule

`default_nettype wire

FILE: hw/rtl/h3uh_accum.sv
// Accumulate stage: XORs the selected rows into the per-word accumulators.
// Depends on h3uh_pkg; row data comes from h3uh_row_store's registered read, in the cycle after the read.
`default_nettype none

module h3uh_accum
	import h3uh_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  key_req_t key,
	input  word_t    rows [WORDS][BYTE_W],
	input  wire      buf_free,
	output logic     stall,
	output logic     load,
	output word_t    words [WORDS]
);

	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;
	logic              last_s1;
	word_t             acc_q [WORDS];

	// a finished key waits here while the output buffer still drains
	assign stall = valid_s1 && last_s1 && !buf_free;
	assign load  = valid_s1 && last_s1 && !stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!stall) begin
			valid_s1 <= key.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (!stall) begin
			byte_s1 <= key.key_byte;
			last_s1 <= key.last_byte;
		end
	end

	for (genvar j = 0; j < WORDS; j++) begin : g_word
		word_t mix;

		always_comb begin
			mix = '0;
			for (int b = 0; b < BYTE_W; b++) begin
				if (byte_s1[b]) begin
					mix = mix ^ rows[j][b];
				end
			end
		end

		assign words[j] = acc_q[j] ^ mix;

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) begin
				acc_q[j] <= '0;
			end else if (valid_s1 && !stall) begin
				acc_q[j] <= last_s1 ? '0 : words[j];
			end
		end
	end

`ifndef SYNTHESIS
	a_acc_cleared: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (acc_q[0] == '0))
		else $error("accumulator not cleared after key end");
`endif

endmodule

`default_nettype wire

FILE: hw/rtl/h3uh_out_buf.sv
// Output buffer: holds the hash words of one key and sends them in order.
// Depends on h3uh_pkg.
`default_nettype none

module h3uh_out_buf
	import h3uh_pkg::*;
(
	input  wire      clk,
	input  wire      arst_n,
	input  wire      load,
	input  word_t    words [WORDS],
	output logic     buf_free,
	output logic     result_valid,
	input  wire      result_ready,
	output result_t  result
);

	localparam int CNT_W = (WORDS > 1) ? $clog2(WORDS) : 1;

	word_t            buf_q [WORDS];
	logic [CNT_W-1:0] cnt_q;
	logic             valid_q;
	logic             last_word;
	logic             taken;

	assign last_word    = (cnt_q == CNT_W'(WORDS - 1));
	assign taken        = valid_q && result_ready;
	assign buf_free     = !valid_q || (result_ready && last_word);
	assign result_valid = valid_q;

	assign result.hash_word  = buf_q[0];
	assign result.word_index = cnt_q[0];
	assign result.last_word  = last_word;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
			cnt_q   <= '0;
		end else if (load) begin
			valid_q <= 1'b1;
			cnt_q   <= '0;
		end else if (taken) begin
			if (last_word) begin
				valid_q <= 1'b0;
			end else begin
				cnt_q <= cnt_q + 1'b1;
			end
		end
	end

	// the current word always sits at the head; shift on each accepted word
	always_ff @(posedge clk) begin
		if (load) begin
			buf_q <= words;
		end else if (taken) begin
			for (int i = 0; i < WORDS - 1; i++) begin
				buf_q[i] <= buf_q[i + 1];
			end
		end
	end

`ifndef SYNTHESIS
	a_load_starts: assert property (@(posedge clk) disable iff (!arst_n)
		load |=> (result_valid && cnt_q == '0))
		else $error("buffer load did not start at word zero");

	a_no_gap: assert property (@(posedge clk) disable iff (!arst_n)
		(taken && !last_word) |=> result_valid)
		else $error("hash words of one key not sent back to back");
`endif

endmodule

`default_nettype wire
